// ===== sv/tld_pkg.sv =====
// Shared types and constants for the TLS extension list deframer.
`timescale 1ns / 1ps
`default_nettype none

package tld_pkg;

    // Parse phase of the extension section.
    typedef enum logic [1:0] {
        PH_OUTSIDE = 2'd0,
        PH_LEN_LO  = 2'd1,
        PH_HEADER  = 2'd2,
        PH_CONTENT = 2'd3
    } tld_phase_t;

    // Role tag attached to every byte.
    typedef enum logic [1:0] {
        ROLE_SECTION_LEN = 2'd0,
        ROLE_HEADER      = 2'd1,
        ROLE_CONTENT     = 2'd2,
        ROLE_OUTSIDE     = 2'd3
    } tld_role_t;

    // Position of a byte within the four-byte entry header.
    localparam logic [1:0] HDR_TYPE_HI = 2'd0;
    localparam logic [1:0] HDR_TYPE_LO = 2'd1;
    localparam logic [1:0] HDR_LEN_HI  = 2'd2;
    localparam logic [1:0] HDR_LEN_LO  = 2'd3;

    // One input transaction.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       section_start;
    } tld_in_t;

    // One result transaction.
    typedef struct packed {
        tld_role_t   byte_role;
        logic [15:0] ext_type;
        logic [15:0] ext_length;
        logic [7:0]  content_byte;
        logic [15:0] content_offset;
        logic        header_done;
        logic        entry_last;
        logic        section_end;
        logic        length_error;
    } tld_out_t;

endpackage

`default_nettype wire

// ===== sv/tls_extension_list_deframer.sv =====
// Top level of the TLS extension list deframer.
//
// The block takes the decrypted handshake stream one byte per transaction on
// the in channel (in_valid, in_ready, in_data). A byte with section_start set
// opens an extension section; the block tags every byte with its role, the
// current entry type and length, and the content offset, and marks the end of
// each header, entry and section. Each input transaction gives exactly one
// result transaction on the out channel (out_valid, out_ready, out_data).
// A byte passes an input register and then a result register, which offers
// its result. Throughput is one byte per cycle while out_ready stays high,
// set by the combinational parse step between the two registers. When
// the receiver stalls, the result register holds its transaction and an empty
// input register still takes one more byte; in_ready then drops until
// out_ready returns. Reset empties both registers and puts the parser outside
// any section with all counters and entry fields at zero.
`timescale 1ns / 1ps
`default_nettype none

module tls_extension_list_deframer (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire tld_pkg::tld_in_t  in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output tld_pkg::tld_out_t      out_data
);

    logic              item_valid;
    tld_pkg::tld_in_t  item;
    logic              advance;
    logic              step;
    tld_pkg::tld_out_t result;

    // A byte is parsed when it sits in the input register and the result
    // register can take it.
    assign step = item_valid && advance;

    tld_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    tld_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (item),
        .result (result)
    );

    tld_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .result     (result),
        .advance    (advance),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule

`default_nettype wire

// ===== sv/tld_in_stage.sv =====
// Input register stage of the deframer.
`timescale 1ns / 1ps
`default_nettype none

module tld_in_stage (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire tld_pkg::tld_in_t in_data,
    input  wire logic             advance,
    output logic                  item_valid,
    output tld_pkg::tld_in_t      item
);

    logic             s1_valid_reg;
    logic             s1_valid_next;
    tld_pkg::tld_in_t s1_item_reg;

    // The stage takes a new transaction when empty or when its item moves on.
    assign in_ready      = !s1_valid_reg || advance;
    assign s1_valid_next = in_ready ? in_valid : s1_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_item_reg <= in_data;
        end
    end

    assign item_valid = s1_valid_reg;
    assign item       = s1_item_reg;

endmodule

`default_nettype wire

// ===== sv/tld_parser.sv =====
// Parse state and per-byte tagging logic of the deframer.
`timescale 1ns / 1ps
`default_nettype none

module tld_parser (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,
    input  wire tld_pkg::tld_in_t item,
    output tld_pkg::tld_out_t     result
);

    tld_pkg::tld_phase_t phase_reg, phase_next;
    logic [1:0]          hdr_count_reg, hdr_count_next;
    logic [15:0]         remaining_reg, remaining_next;
    logic [15:0]         type_reg, type_next;
    logic [15:0]         length_reg, length_next;
    logic [15:0]         content_count_reg, content_count_next;

    logic [7:0]  b;
    logic [15:0] rem_len_lo;
    logic [15:0] rem_dec;
    logic        rem_hits_zero;
    logic [15:0] hdr_type_new;
    logic [15:0] hdr_len_new;
    logic        content_last;

    assign b = item.in_byte;

    // Section count after the low length byte, and after consuming one byte.
    assign rem_len_lo    = remaining_reg | {8'h00, b};
    assign rem_dec       = (remaining_reg == 16'h0000) ? 16'h0000 : remaining_reg - 16'd1;
    assign rem_hits_zero = (remaining_reg == 16'd1);

    // Header fields with this byte merged in.
    assign hdr_type_new = (hdr_count_reg == tld_pkg::HDR_TYPE_HI) ? {b, 8'h00} :
                          (hdr_count_reg == tld_pkg::HDR_TYPE_LO) ? {type_reg[15:8], b} :
                          type_reg;
    assign hdr_len_new  = (hdr_count_reg == tld_pkg::HDR_LEN_HI) ? {b, 8'h00} :
                          (hdr_count_reg == tld_pkg::HDR_LEN_LO) ? {length_reg[15:8], b} :
                          length_reg;

    // Last content byte of the entry.
    assign content_last = ({1'b0, content_count_reg} + 17'd1) >= {1'b0, length_reg};

    // Next state.
    always_comb
    begin
        phase_next         = phase_reg;
        hdr_count_next     = hdr_count_reg;
        remaining_next     = remaining_reg;
        type_next          = type_reg;
        length_next        = length_reg;
        content_count_next = content_count_reg;
        if (item.section_start)
        begin
            remaining_next     = {b, 8'h00};
            type_next          = 16'h0000;
            length_next        = 16'h0000;
            hdr_count_next     = 2'd0;
            content_count_next = 16'h0000;
            phase_next         = tld_pkg::PH_LEN_LO;
        end
        else
        begin
            unique case (phase_reg)
                tld_pkg::PH_LEN_LO:
                begin
                    remaining_next = rem_len_lo;
                    hdr_count_next = 2'd0;
                    phase_next     = (rem_len_lo == 16'h0000) ? tld_pkg::PH_OUTSIDE
                                                              : tld_pkg::PH_HEADER;
                end
                tld_pkg::PH_HEADER:
                begin
                    type_next      = hdr_type_new;
                    length_next    = hdr_len_new;
                    remaining_next = rem_dec;
                    if (hdr_count_reg != tld_pkg::HDR_LEN_LO)
                    begin
                        hdr_count_next = hdr_count_reg + 2'd1;
                        if (rem_dec == 16'h0000)
                        begin
                            phase_next = tld_pkg::PH_OUTSIDE;
                        end
                    end
                    else
                    begin
                        hdr_count_next = 2'd0;
                        if (hdr_len_new == 16'h0000)
                        begin
                            phase_next = (rem_dec == 16'h0000) ? tld_pkg::PH_OUTSIDE
                                                               : tld_pkg::PH_HEADER;
                        end
                        else
                        begin
                            content_count_next = 16'h0000;
                            phase_next         = tld_pkg::PH_CONTENT;
                        end
                    end
                end
                tld_pkg::PH_CONTENT:
                begin
                    remaining_next = rem_dec;
                    if (content_last)
                    begin
                        content_count_next = 16'h0000;
                        hdr_count_next     = 2'd0;
                        phase_next         = (rem_dec == 16'h0000) ? tld_pkg::PH_OUTSIDE
                                                                   : tld_pkg::PH_HEADER;
                    end
                    else
                    begin
                        content_count_next = content_count_reg + 16'd1;
                    end
                end
                tld_pkg::PH_OUTSIDE:
                begin
                    phase_next = tld_pkg::PH_OUTSIDE;
                end
            endcase
        end
    end

    // Result tags for the current byte.
    always_comb
    begin
        result                = '0;
        result.byte_role      = tld_pkg::ROLE_OUTSIDE;
        result.ext_type       = type_next;
        result.ext_length     = length_next;
        if (item.section_start)
        begin
            result.byte_role = tld_pkg::ROLE_SECTION_LEN;
        end
        else
        begin
            unique case (phase_reg)
                tld_pkg::PH_LEN_LO:
                begin
                    result.byte_role   = tld_pkg::ROLE_SECTION_LEN;
                    result.section_end = (rem_len_lo == 16'h0000);
                end
                tld_pkg::PH_HEADER:
                begin
                    result.byte_role   = tld_pkg::ROLE_HEADER;
                    result.section_end = rem_hits_zero;
                    if (hdr_count_reg == tld_pkg::HDR_LEN_LO)
                    begin
                        result.header_done  = 1'b1;
                        result.length_error = (hdr_len_new > rem_dec);
                        result.entry_last   = (hdr_len_new == 16'h0000);
                    end
                    else
                    begin
                        result.length_error = (rem_dec == 16'h0000);
                    end
                end
                tld_pkg::PH_CONTENT:
                begin
                    result.byte_role      = tld_pkg::ROLE_CONTENT;
                    result.content_byte   = b;
                    result.content_offset = content_count_reg;
                    result.section_end    = rem_hits_zero;
                    result.entry_last     = content_last;
                end
                tld_pkg::PH_OUTSIDE:
                begin
                    result.byte_role = tld_pkg::ROLE_OUTSIDE;
                end
            endcase
        end
    end

    // State registers advance once per processed byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= tld_pkg::PH_OUTSIDE;
            hdr_count_reg     <= 2'd0;
            remaining_reg     <= 16'h0000;
            type_reg          <= 16'h0000;
            length_reg        <= 16'h0000;
            content_count_reg <= 16'h0000;
        end
        else if (step)
        begin
            phase_reg         <= phase_next;
            hdr_count_reg     <= hdr_count_next;
            remaining_reg     <= remaining_next;
            type_reg          <= type_next;
            length_reg        <= length_next;
            content_count_reg <= content_count_next;
        end
    end

`ifndef ASSERT_OFF
    // Inside an entry header there is always section left to read.
    a_header_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == tld_pkg::PH_HEADER |-> remaining_reg != 16'h0000)
        else $error("header phase with empty section count");

    // Content phase is only entered for an entry with a nonzero length.
    a_content_nonzero_len: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == tld_pkg::PH_CONTENT |-> length_reg != 16'h0000)
        else $error("content phase with zero entry length");

    // A completed header restarts the header byte count.
    a_header_count_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        step && result.header_done |=> hdr_count_reg == 2'd0)
        else $error("header count not cleared after header");

    // A header cut short by the section end leaves the section.
    a_truncated_header_exits: assert property (@(posedge clk) disable iff (!rst_n)
        step && result.length_error && !result.header_done
        |=> phase_reg == tld_pkg::PH_OUTSIDE)
        else $error("truncated header did not leave the section");
`endif

endmodule

`default_nettype wire

// ===== sv/tld_out_stage.sv =====
// Result register stage of the deframer.
`timescale 1ns / 1ps
`default_nettype none

module tld_out_stage (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    input  wire tld_pkg::tld_out_t result,
    output logic                   advance,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output tld_pkg::tld_out_t      out_data
);

    logic              out_valid_reg;
    logic              out_valid_next;
    tld_pkg::tld_out_t out_data_reg;

    // The register can load when empty or when its transaction is taken.
    assign advance        = !out_valid_reg || out_ready;
    assign out_valid_next = advance ? item_valid : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && item_valid)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire
